FILE: src/sart_pkg.sv
// ---------------------------------------------------------------------------
// sart_pkg: shared types and codes for the sorted address range table
// Entry and command structs that travel along the cell chain, field widths
// and request/status codes.
// ---------------------------------------------------------------------------
package sart_pkg;

	localparam int ADDR_W = 32;
	localparam int LEN_W  = 24;
	localparam int POOL_W = 3;
	localparam int END_W  = ADDR_W + 1;

	// request kinds
	localparam logic REQ_REGISTER = 1'b0;
	localparam logic REQ_LOOKUP   = 1'b1;

	// result status
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// one stored range
	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [END_W-1:0]  end_addr;
		logic [POOL_W-1:0] owner;
	} sart_entry_t;

	// request broadcast to every cell
	typedef struct packed {
		logic              insert;
		logic [ADDR_W-1:0] addr;
		sart_entry_t       entry;
	} sart_cmd_t;

	// per-cell status handed back to the top level
	typedef struct packed {
		logic              le;
		logic              hit;
		logic [POOL_W-1:0] owner_sel;
	} sart_cell_stat_t;

endpackage

FILE: src/sart_cell.sv
// ---------------------------------------------------------------------------
// sart_cell: one slot of the sorted range chain
// Holds one range, compares its base and end against the broadcast address,
// and on an insert either keeps its range, takes the new one, or takes its
// lower neighbor's range so the table stays sorted.
// ---------------------------------------------------------------------------
module sart_cell
	import sart_pkg::*;
(
	input  logic            clk,
	input  sart_cmd_t       cmd,
	input  logic            occ,        // slot holds a written range
	input  logic            prev_le,    // lower neighbor base <= addr (1 for slot 0)
	input  sart_entry_t     prev_entry, // lower neighbor range
	input  logic            next_le,    // upper neighbor base <= addr (0 for last slot)
	output logic            le,
	output sart_entry_t     entry,
	output sart_cell_stat_t stat
);

	sart_entry_t entry_q;
	logic        in_range;

	// base at or below the address, only for occupied slots
	assign le       = occ && (entry_q.base <= cmd.addr);
	assign in_range = {1'b0, cmd.addr} < entry_q.end_addr;
	assign entry    = entry_q;

	// last slot with base at or below the address decides the lookup
	assign stat.le        = le;
	assign stat.hit       = le && !next_le && in_range;
	assign stat.owner_sel = stat.hit ? entry_q.owner : '0;

	// insert: first slot above the address takes the new range, the rest shift up
	always_ff @(posedge clk) begin
		if (cmd.insert && !le) begin
			entry_q <= prev_le ? cmd.entry : prev_entry;
		end
	end

endmodule

FILE: src/sorted_address_range_table.sv
// ---------------------------------------------------------------------------
// sorted_address_range_table: range table kept sorted by base, with lookup
// Stores up to MAX_RANGES ranges [base, base+length) with an owner pool tag
// in a chain of compare cells and answers register and lookup requests.
// ---------------------------------------------------------------------------
// Each request passes through ST_IDLE, which captures the beat and forms the
// 33-bit range end, and ST_EXEC, in which every cell compares its base with
// the address at once and, for a register request, the chain shifts by one
// slot to open the insert position. The result goes to an output register,
// so a new request is taken right after the result is formed, while the
// result waits for the sink; no new request is taken until the current one
// has left ST_EXEC. A register request into a full table leaves the table
// unchanged and returns status 1. A lookup tests only the last range whose
// base is at or below the address. No clearing pass is needed after reset.
module sorted_address_range_table
	import sart_pkg::*;
#(
	parameter int MAX_RANGES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // address[31:0], block_length[55:32], pool_index[58:56], zero
	input  logic        s_tuser,  // req_type
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // found[0], owner_pool[3:1], status_code[4], zero
);

	localparam int CW = $clog2(MAX_RANGES + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic              state_q;
	logic [CW-1:0]     count_q;
	logic              req_type_q;
	logic [ADDR_W-1:0] addr_q;
	logic [END_W-1:0]  end_q;
	logic [POOL_W-1:0] pool_q;
	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;

	logic              accept;
	logic              go;
	logic              full;
	logic              hit_any;
	logic [POOL_W-1:0] owner_any;
	sart_cmd_t         cmd;

	logic            [MAX_RANGES-1:0] occ;
	logic            [MAX_RANGES-1:0] le;
	logic            [MAX_RANGES-1:0] hit_vec;
	sart_entry_t     [MAX_RANGES-1:0] entries;
	sart_cell_stat_t [MAX_RANGES-1:0] stats;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CW'(MAX_RANGES));
	assign go       = (state_q == ST_EXEC) && (!m_tvalid_q || m_tready);

	// command broadcast to the chain
	assign cmd.insert         = go && (req_type_q == REQ_REGISTER) && !full;
	assign cmd.addr           = addr_q;
	assign cmd.entry.base     = addr_q;
	assign cmd.entry.end_addr = end_q;
	assign cmd.entry.owner    = pool_q;

	// cell chain
	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		assign occ[i]     = CW'(i) < count_q;
		assign hit_vec[i] = stats[i].hit;
		if (i == 0) begin : g_first
			sart_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.occ        (occ[i]),
				.prev_le    (1'b1),
				.prev_entry (cmd.entry),
				.next_le    (le[i+1]),
				.le         (le[i]),
				.entry      (entries[i]),
				.stat       (stats[i])
			);
		end else if (i == MAX_RANGES - 1) begin : g_last
			sart_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.occ        (occ[i]),
				.prev_le    (le[i-1]),
				.prev_entry (entries[i-1]),
				.next_le    (1'b0),
				.le         (le[i]),
				.entry      (entries[i]),
				.stat       (stats[i])
			);
		end else begin : g_mid
			sart_cell u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.occ        (occ[i]),
				.prev_le    (le[i-1]),
				.prev_entry (entries[i-1]),
				.next_le    (le[i+1]),
				.le         (le[i]),
				.entry      (entries[i]),
				.stat       (stats[i])
			);
		end
	end

	// at most one cell reports, so an or across the chain selects its owner
	always_comb begin
		hit_any   = 1'b0;
		owner_any = '0;
		for (int i = 0; i < MAX_RANGES; i++) begin
			hit_any   = hit_any | stats[i].hit;
			owner_any = owner_any | stats[i].owner_sel;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.insert) count_q <= count_q + CW'(1);
			if (go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// request capture, end formed with a carry bit
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= s_tuser;
			addr_q     <= s_tdata[31:0];
			end_q      <= {1'b0, s_tdata[31:0]} + {9'd0, s_tdata[55:32]};
			pool_q     <= s_tdata[58:56];
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (go) begin
			m_tdata_q[7:5] <= '0;
			if (req_type_q == REQ_LOOKUP) begin
				m_tdata_q[0]   <= hit_any;
				m_tdata_q[3:1] <= owner_any;
				m_tdata_q[4]   <= STATUS_DONE;
			end else begin
				m_tdata_q[0]   <= 1'b0;
				m_tdata_q[3:1] <= '0;
				m_tdata_q[4]   <= full ? STATUS_FULL : STATUS_DONE;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RANGES))
		else $error("range count above table size");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell claims the lookup");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the table");

	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tdata_q[4] == STATUS_FULL) |-> !m_tdata_q[0])
		else $error("dropped register reports a hit");

endmodule

FILE: tb/sv/sorted_address_range_table_test.sv
// ---------------------------------------------------------------------------
// sorted_address_range_table_test: self-checking bench for the range table
// A directed table of register and lookup beats covers the empty table, zero
// and maximum lengths, equal bases, range ends past 32 bits and overlapping
// ranges. Random traffic then fills the table and keeps probing it, checked
// beat by beat against a behavioral copy of the sorted table, while both
// stream sides idle in several patterns.
// ---------------------------------------------------------------------------
module sorted_address_range_table_test
	import sart_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH      = 64;
	localparam int RAND_ITEMS       = 1632;
	localparam int PHASE_LEN        = RAND_ITEMS / 4;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES     = 20;
	localparam int CYCLE_LIMIT      = 300000;
	localparam int MAX_REPORTS      = 10;

	// one request beat as the block sees it
	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic [POOL_W-1:0] pool;
	} range_req_t;

	// one result beat
	typedef struct packed {
		logic              found;
		logic [POOL_W-1:0] owner;
		logic              status;
	} range_resp_t;

	// directed row: request plus an optional hand-written result
	typedef struct packed {
		range_req_t  req;
		logic        exp_given;
		range_resp_t exp;
	} dir_row_t;

	localparam range_resp_t RESP_NONE = '{1'b0, 3'd0, STATUS_DONE};
	localparam int N_DIRECTED = 21;

	localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// empty table misses everywhere
		'{'{REQ_LOOKUP,   32'h0000_0000, 24'h000000, 3'd0}, 1'b1, RESP_NONE},
		'{'{REQ_LOOKUP,   32'hFFFF_FFFF, 24'hFFFFFF, 3'd7}, 1'b1, RESP_NONE},
		// zero length range is never hit
		'{'{REQ_REGISTER, 32'h0000_0000, 24'h000000, 3'd5}, 1'b1, RESP_NONE},
		'{'{REQ_LOOKUP,   32'h0000_0000, 24'h000000, 3'd0}, 1'b1, RESP_NONE},
		// end beyond 32 bits
		'{'{REQ_REGISTER, 32'hFFFF_FFFF, 24'hFFFFFF, 3'd7}, 1'b1, RESP_NONE},
		'{'{REQ_LOOKUP,   32'hFFFF_FFFF, 24'h000000, 3'd0}, 1'b1,
			'{1'b1, 3'd7, STATUS_DONE}},
		// last byte in, end byte out, address between ranges
		'{'{REQ_REGISTER, 32'h8000_0000, 24'h000010, 3'd2}, 1'b1, RESP_NONE},
		'{'{REQ_LOOKUP,   32'h8000_000F, 24'h123456, 3'd3}, 1'b1,
			'{1'b1, 3'd2, STATUS_DONE}},
		'{'{REQ_LOOKUP,   32'h8000_0010, 24'h000000, 3'd0}, 1'b1, RESP_NONE},
		'{'{REQ_LOOKUP,   32'h7FFF_FFFF, 24'h000000, 3'd0}, 1'b1, RESP_NONE},
		// equal bases keep arrival order, newest is tested
		'{'{REQ_REGISTER, 32'h8000_0000, 24'h000100, 3'd6}, 1'b1, RESP_NONE},
		'{'{REQ_LOOKUP,   32'h8000_0000, 24'h000000, 3'd0}, 1'b0, RESP_NONE},
		'{'{REQ_LOOKUP,   32'h8000_0050, 24'h000000, 3'd0}, 1'b0, RESP_NONE},
		// shorter newest range hides the older overlapping ones
		'{'{REQ_REGISTER, 32'h8000_0000, 24'h000004, 3'd1}, 1'b1, RESP_NONE},
		'{'{REQ_LOOKUP,   32'h8000_0008, 24'h000000, 3'd0}, 1'b0, RESP_NONE},
		// maximum length
		'{'{REQ_REGISTER, 32'h0000_1000, 24'hFFFFFF, 3'd0}, 1'b1, RESP_NONE},
		'{'{REQ_LOOKUP,   32'h0100_0FFE, 24'h000000, 3'd0}, 1'b0, RESP_NONE},
		'{'{REQ_LOOKUP,   32'h0100_0FFF, 24'h000000, 3'd0}, 1'b0, RESP_NONE},
		// zero length on top of the highest base
		'{'{REQ_REGISTER, 32'hFFFF_FFFF, 24'h000000, 3'd3}, 1'b1, RESP_NONE},
		'{'{REQ_LOOKUP,   32'hFFFF_FFFF, 24'h000000, 3'd0}, 1'b1, RESP_NONE},
		'{'{REQ_LOOKUP,   32'hFFFF_FFFE, 24'h000000, 3'd0}, 1'b0, RESP_NONE}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;  // address[31:0], block_length[55:32], pool_index[58:56], zero
	logic        s_tuser;  // req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;  // found[0], owner_pool[3:1], status_code[4], zero

	// behavioral copy of the sorted table
	logic [ADDR_W-1:0] tbl_base  [TABLE_DEPTH];
	logic [END_W-1:0]  tbl_end   [TABLE_DEPTH];
	logic [POOL_W-1:0] tbl_owner [TABLE_DEPTH];
	int                tbl_count = 0;

	range_resp_t pending_results [$];
	int          mismatch_cnt  = 0;
	int          cycle_cnt     = 0;
	int          src_idle_pct  = 0;
	int          snk_stall_pct = 0;
	bit          long_hold_req = 1'b0;

	sorted_address_range_table #(
		.MAX_RANGES(TABLE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// apply one request to the table copy and return its result
	function automatic range_resp_t table_apply(range_req_t r);
		range_resp_t res;
		int          pos;
		int          i;
		res = RESP_NONE;
		pos = 0;
		for (i = 0; i < tbl_count; i++) begin
			if (tbl_base[i] <= r.addr) pos = i + 1;
		end
		if (r.kind == REQ_REGISTER) begin
			if (tbl_count >= TABLE_DEPTH) begin
				res.status = STATUS_FULL;
			end else begin
				for (i = tbl_count; i > pos; i--) begin
					tbl_base[i]  = tbl_base[i-1];
					tbl_end[i]   = tbl_end[i-1];
					tbl_owner[i] = tbl_owner[i-1];
				end
				tbl_base[pos]  = r.addr;
				tbl_end[pos]   = {1'b0, r.addr} + END_W'(r.len);
				tbl_owner[pos] = r.pool;
				tbl_count++;
			end
		end else if (pos > 0 && {1'b0, r.addr} < tbl_end[pos-1]) begin
			res.found = 1'b1;
			res.owner = tbl_owner[pos-1];
		end
		return res;
	endfunction

	// offer one beat, wait for acceptance, record the expected result
	task automatic offer_request(range_req_t r, logic exp_given, range_resp_t exp);
		range_resp_t predicted;
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, r.pool, r.len, r.addr};
		s_tuser  <= r.kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = table_apply(r);
		pending_results.insert(pending_results.size(), exp_given ? exp : predicted);
	endtask

	// stop offering until every outstanding result has come back
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// stimulus
	initial begin : stimulus
		range_req_t req;
		int         phase;
		int         k;
		int         span;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= REQ_REGISTER;
		arst_n   <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[r])
			offer_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].exp_given,
				DIRECTED_ROWS[r].exp);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			// idle pattern per phase, sender pauses at each boundary
			if (i % PHASE_LEN == 0) begin
				wait_results_drained();
				phase = i / PHASE_LEN;
				src_idle_pct  = (phase == 1) ? 73 : (phase == 3) ? 10 : 0;
				snk_stall_pct = (phase == 2) ? 73 : (phase == 3) ? 10 : 0;
			end
			if (i == 150) long_hold_req = 1'b1;

			req.pool = 3'($urandom);
			req.len  = 24'($urandom);
			if ($urandom_range(99) < ((tbl_count < TABLE_DEPTH) ? 10 : 5)) begin
				// register: random, duplicate, neighbor or extreme base
				req.kind = REQ_REGISTER;
				k = $urandom_range(0, tbl_count - 1);
				case ($urandom_range(0, 3))
					0: req.addr = $urandom;
					1: req.addr = tbl_base[k];
					2: req.addr = tbl_base[k] + 32'($urandom_range(0, 64)) - 32'd32;
					default: begin
						req.addr = $urandom_range(1) ? 32'($urandom_range(0, 255))
							: 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
					end
				endcase
				case ($urandom_range(0, 3))
					0: req.len = '0;
					1: req.len = '1;
					2: req.len = 24'($urandom_range(1, 4096));
					default: req.len = 24'($urandom);
				endcase
			end else begin
				// lookup at random, inside or around the edges of a stored range
				req.kind = REQ_LOOKUP;
				k = $urandom_range(0, tbl_count - 1);
				span = int'(tbl_end[k] - {1'b0, tbl_base[k]});
				case ($urandom_range(0, 5))
					0: req.addr = $urandom;
					1: req.addr = tbl_base[k] - 32'd1;
					2: req.addr = tbl_base[k];
					3: req.addr = tbl_end[k][ADDR_W-1:0] - 32'd1;
					4: req.addr = tbl_end[k][ADDR_W-1:0];
					default: begin
						req.addr = tbl_base[k] +
							((span > 0) ? 32'($urandom_range(0, span - 1)) : 32'd0);
					end
				endcase
			end
			offer_request(req, 1'b0, RESP_NONE);
		end

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("sorted_address_range_table_test OK");
		else
			$display("sorted_address_range_table_test NOT OK");
		$finish;
	end

	// result sink with random stalls and one long hold-off
	initial begin : result_sink
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin : result_check
		range_resp_t got;
		range_resp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[0], m_tdata[3:1], m_tdata[4]};
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("unexpected result beat: found=%0d owner=%0d status=%0d",
						got.found, got.owner, got.status);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("result mismatch: exp found=%0d owner=%0d status=%0d, %s",
							want.found, want.owner, want.status,
							$sformatf("got found=%0d owner=%0d status=%0d",
								got.found, got.owner, got.status));
				end
			end
		end
	end

	// timeout
	always @(posedge clk) begin : watchdog
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("sorted_address_range_table_test NOT OK");
			$finish;
		end
	end

endmodule
